/* sv/lls_pkg.sv */
// ----------------------------------------------------------------------------
// Lattice LPC synthesis filter package
// Shared widths, command codes, control word types and saturation helpers.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int unsigned MAX_ORDER_DEFAULT = 16;

  localparam int unsigned OrderW  = 5;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned AccW    = 24;
  localparam int unsigned ProdW   = AccW + CoefW;
  localparam int unsigned FracW   = 15;
  // A sum of an accumulator value and a shifted product needs two guard bits.
  localparam int unsigned SumW    = AccW + 2;

  localparam logic [OrderW-1:0] ORDER_RST = 5'd10;

  typedef enum logic [1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_FILTER    = 2'd1,
    CMD_CLEAR     = 2'd2
  } cmd_e;

  // Multiplier operand selection: history times coefficient, or s times coefficient.
  typedef enum logic {
    MUL_HK = 1'b0,
    MUL_SK = 1'b1
  } mul_sel_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_STAGE = 2'd1,
    WR_ONE   = 2'd2,
    WR_ZERO  = 2'd3
  } wr_sel_e;

  // History read address relative to the stage counter.
  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_M1 = 2'd1,
    RD_IDX_M2 = 2'd2
  } rd_ofs_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     k_prev;
    logic     rd_en;
    rd_ofs_e  rd_ofs;
    wr_sel_e  wr_sel;
    logic     shift;
    logic     sub;
    logic     dec;
    logic     first_set;
    logic     emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic start;
    logic order_zero;
    logic idx_zero;
    logic out_busy;
  } seq_stat_t;

  function automatic logic signed [AccW-1:0] sat_acc(logic signed [SumW-1:0] v);
    logic signed [AccW-1:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7f_ffff;
    end else if (v < -26'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SampleW-1:0] sat_sample(logic signed [AccW-1:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/lls_hist_mem.sv */
// ----------------------------------------------------------------------------
// Lattice history memory
// One write port, one registered read port, per-entry valid bits that make
// a cleared or never written entry read as zero.
// ----------------------------------------------------------------------------
module lls_hist_mem #(
  parameter int unsigned Depth = 17,
  parameter int unsigned AddrW = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clr_i,
  input  logic                              we_i,
  input  logic [AddrW-1:0]                  waddr_i,
  input  logic signed [lls_pkg::AccW-1:0]   wdata_i,
  input  logic                              re_i,
  input  logic [AddrW-1:0]                  raddr_i,
  output logic signed [lls_pkg::AccW-1:0]   rdata_o
);
  import lls_pkg::*;

  logic signed [AccW-1:0] mem_q [Depth];
  logic [Depth-1:0]       vld_q;
  logic signed [AccW-1:0] rd_q;
  logic                   rd_vld_q;
  logic                   raddr_ok;
  logic                   waddr_ok;

  assign raddr_ok = 32'(raddr_i) < Depth;
  assign waddr_ok = 32'(waddr_i) < Depth;

  always_ff @(posedge clk_i) begin
    if (we_i && waddr_ok) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i && raddr_ok) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i && waddr_ok) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= raddr_ok && vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/lls_seq.sv */
// ----------------------------------------------------------------------------
// Lattice filter microsequencer
// Step counter and control store that drive the datapath through one sample.
// ----------------------------------------------------------------------------
module lls_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lls_pkg::seq_stat_t   stat_i,
  output lls_pkg::dp_ctrl_t    ctrl_o,
  output logic                 idle_o
);
  import lls_pkg::*;

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_LOAD = 3'd1;
  localparam logic [2:0] STEP_PRE  = 3'd2;
  localparam logic [2:0] STEP_STA  = 3'd3;
  localparam logic [2:0] STEP_STB  = 3'd4;
  localparam logic [2:0] STEP_TAIL = 3'd5;
  localparam logic [2:0] STEP_FIN  = 3'd6;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_DISPATCH = 3'd1,
    JMP_ORDER0   = 3'd2,
    JMP_LOOP     = 3'd3,
    JMP_DONE     = 3'd4
  } jmp_e;

  typedef struct packed {
    jmp_e       jmp;
    logic [2:0] target;
    dp_ctrl_t   dp;
  } ucode_t;

  function automatic ucode_t rom(logic [2:0] pc);
    ucode_t w;
    w        = '0;
    w.jmp    = JMP_NEXT;
    w.target = STEP_IDLE;
    case (pc)
      STEP_IDLE: begin
        w.jmp    = JMP_DISPATCH;
        w.target = STEP_LOAD;
      end
      STEP_LOAD: begin
        w.dp.rd_en  = 1'b1;
        w.dp.rd_ofs = RD_IDX;
        w.jmp       = JMP_ORDER0;
        w.target    = STEP_FIN;
      end
      STEP_PRE: begin
        w.dp.mul_en    = 1'b1;
        w.dp.mul_sel   = MUL_HK;
        w.dp.shift     = 1'b1;
        w.dp.first_set = 1'b1;
        w.dp.rd_en     = 1'b1;
        w.dp.rd_ofs    = RD_IDX_M1;
      end
      STEP_STA: begin
        w.dp.sub     = 1'b1;
        w.dp.mul_en  = 1'b1;
        w.dp.mul_sel = MUL_HK;
        w.dp.k_prev  = 1'b1;
        w.dp.shift   = 1'b1;
        w.dp.wr_sel  = WR_STAGE;
      end
      STEP_STB: begin
        w.dp.mul_en  = 1'b1;
        w.dp.mul_sel = MUL_SK;
        w.dp.rd_en   = 1'b1;
        w.dp.rd_ofs  = RD_IDX_M2;
        w.dp.dec     = 1'b1;
        w.jmp        = JMP_LOOP;
        w.target     = STEP_STA;
      end
      STEP_TAIL: begin
        w.dp.wr_sel = WR_ONE;
      end
      STEP_FIN: begin
        w.dp.wr_sel = WR_ZERO;
        w.dp.emit   = 1'b1;
        w.jmp       = JMP_DONE;
        w.target    = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_DONE;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [2:0] pc_q, pc_d;
  ucode_t     uw;
  logic       stall;

  assign uw    = rom(pc_q);
  // The final step waits until the output register is free.
  assign stall = (uw.jmp == JMP_DONE) && stat_i.out_busy;

  always_comb begin
    pc_d = pc_q + 3'd1;
    case (uw.jmp)
      JMP_NEXT:     pc_d = pc_q + 3'd1;
      JMP_DISPATCH: pc_d = stat_i.start ? uw.target : pc_q;
      JMP_ORDER0:   pc_d = stat_i.order_zero ? uw.target : pc_q + 3'd1;
      JMP_LOOP:     pc_d = stat_i.idx_zero ? pc_q + 3'd1 : uw.target;
      JMP_DONE:     pc_d = stall ? pc_q : uw.target;
      default:      pc_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = stall ? '0 : uw.dp;
  assign idle_o = (pc_q == STEP_IDLE);

endmodule

/* sv/lls_datapath.sv */
// ----------------------------------------------------------------------------
// Lattice filter datapath
// Coefficient store, shared multiplier, accumulator, history memory and the
// output register.
// ----------------------------------------------------------------------------
module lls_datapath #(
  parameter int unsigned MaxOrder = lls_pkg::MAX_ORDER_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lls_pkg::dp_ctrl_t                    ctrl_i,
  input  logic                                 start_i,
  input  logic                                 coef_we_i,
  input  logic                                 clear_i,
  input  logic [lls_pkg::OrderW-1:0]           active_order_i,
  input  logic [3:0]                           coef_index_i,
  input  logic signed [lls_pkg::CoefW-1:0]     coef_value_i,
  input  logic signed [lls_pkg::SampleW-1:0]   residual_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [lls_pkg::SampleW-1:0]   output_sample_o,
  output logic                                 order_zero_o,
  output logic                                 idx_zero_o,
  output logic                                 out_busy_o
);
  import lls_pkg::*;

  localparam int unsigned IdxW  = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;
  localparam int unsigned AddrW = $clog2(MaxOrder + 1);
  localparam int unsigned Depth = MaxOrder + 1;

  logic signed [CoefW-1:0]   coef_q [MaxOrder];
  logic [IdxW-1:0]           idx_q;
  logic                      first_q;
  logic signed [AccW-1:0]    s_q;
  logic signed [ProdW-1:0]   hk_q;
  logic signed [ProdW-1:0]   sk_q;
  logic signed [AccW-1:0]    h_cur_q;
  logic signed [CoefW-1:0]   k_cur_q;
  logic signed [AccW-1:0]    h_wr_q;
  logic signed [CoefW-1:0]   k_sk_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;

  logic [AddrW-1:0]          n_eff;
  logic [IdxW-1:0]           kidx;
  logic signed [CoefW-1:0]   k_rd;
  logic signed [AccW-1:0]    h_rd;
  logic signed [AccW-1:0]    mul_a;
  logic signed [CoefW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW-1:0]    s_new;
  logic signed [AccW-1:0]    h_new;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr;
  logic signed [AccW-1:0]    mem_wdata;
  logic [AddrW-1:0]          mem_raddr;

  // Orders above the store size run all stages.
  assign n_eff = (32'(active_order_i) > MaxOrder) ? AddrW'(MaxOrder)
                                                  : AddrW'(active_order_i);

  assign kidx = idx_q - IdxW'(ctrl_i.k_prev);
  assign k_rd = (32'(kidx) < MaxOrder) ? coef_q[kidx] : '0;

  assign mul_a = (ctrl_i.mul_sel == MUL_SK) ? s_q : h_rd;
  assign mul_b = (ctrl_i.mul_sel == MUL_SK) ? k_sk_q : k_rd;
  assign prod  = mul_a * mul_b;

  assign s_new = sat_acc(SumW'(s_q) - SumW'($signed(hk_q[ProdW-1:FracW])));
  assign h_new = sat_acc(SumW'(h_wr_q) + SumW'($signed(sk_q[ProdW-1:FracW])));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = h_new;
    case (ctrl_i.wr_sel)
      WR_NONE: begin
        mem_we = 1'b0;
      end
      WR_STAGE: begin
        mem_we    = !first_q;
        mem_waddr = AddrW'(idx_q) + AddrW'(2);
      end
      WR_ONE: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(1);
      end
      WR_ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = s_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_raddr = AddrW'(idx_q) - AddrW'(ctrl_i.rd_ofs);

  lls_hist_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clear_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (mem_raddr),
    .rdata_o (h_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MaxOrder); i++) begin
        coef_q[i] <= '0;
      end
    end else if (coef_we_i && (32'(coef_index_i) < MaxOrder)) begin
      coef_q[IdxW'(coef_index_i)] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q <= AccW'(residual_i);
    end else if (ctrl_i.sub) begin
      s_q <= s_new;
    end
    if (ctrl_i.mul_en) begin
      if (ctrl_i.mul_sel == MUL_SK) begin
        sk_q <= prod;
      end else begin
        hk_q <= prod;
      end
    end
    if (ctrl_i.shift) begin
      h_cur_q <= h_rd;
      k_cur_q <= k_rd;
      h_wr_q  <= h_cur_q;
      k_sk_q  <= k_cur_q;
    end
    if (ctrl_i.emit) begin
      out_sample_q <= sat_sample(s_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        idx_q <= IdxW'(n_eff - AddrW'(1));
      end else if (ctrl_i.dec && (idx_q != '0)) begin
        idx_q <= idx_q - IdxW'(1);
      end
      if (ctrl_i.first_set) begin
        first_q <= 1'b1;
      end else if (ctrl_i.sub) begin
        first_q <= 1'b0;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign output_sample_o = out_sample_q;
  assign order_zero_o    = (n_eff == '0);
  assign idx_zero_o      = (idx_q == '0);
  assign out_busy_o      = out_valid_q && !out_ready_i;

endmodule

/* sv/lattice_lpc_synthesis_filter.sv */
// ----------------------------------------------------------------------------
// Lattice LPC synthesis filter
// All-pole lattice that rebuilds audio samples from an LPC residual.
// ----------------------------------------------------------------------------
// Each input transaction carries a command. Loading a reflection coefficient
// (signed Q1.15) and clearing the lattice history produce no output.
// Filtering a residual sample runs the active stages from the highest down
// to stage zero and produces one output transaction with the reconstructed
// sample, saturated to 16 bits. The number of active stages is active_order
// capped at MaxOrder. A filter transaction occupies the block from acceptance
// until the sequencer returns to its idle step; no new input is taken before
// then. The single shared 24x16 multiplier forms two products per stage, one
// per cycle. The output sits in its own register, so a filtered sample
// waiting to be taken does not stop new load or clear transactions, nor the
// next sample's stages; only the final step of the next sample waits for
// that register. active_order is written through the configuration channel
// by the user only while the block is idle; the block does not enforce this.
// active_order resets to 10. Reset clears the coefficients and the history.
// ----------------------------------------------------------------------------
module lattice_lpc_synthesis_filter #(
  parameter int unsigned MaxOrder = lls_pkg::MAX_ORDER_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration channel: one register, active_order.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lls_pkg::OrderW-1:0]          cfg_active_order_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [3:0]                          coef_index_i,
  input  logic signed [lls_pkg::CoefW-1:0]    coef_value_i,
  input  logic signed [lls_pkg::SampleW-1:0]  residual_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lls_pkg::SampleW-1:0]  output_sample_o
);
  import lls_pkg::*;

  logic [OrderW-1:0] active_order_q;
  logic              in_accept;
  logic              seq_idle;
  seq_stat_t         stat;
  dp_ctrl_t          ctrl;
  logic              order_zero;
  logic              idx_zero;
  logic              out_busy;

  // The configuration register is always writable; the user only writes it
  // while no transaction is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_order_q <= ORDER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_order_q <= cfg_active_order_i;
    end
  end

  // New transactions are taken only while the sequencer rests in its idle step.
  assign in_ready_o = seq_idle;
  assign in_accept  = in_valid_i && in_ready_o;

  assign stat.start      = in_accept && (command_i == CMD_FILTER);
  assign stat.order_zero = order_zero;
  assign stat.idx_zero   = idx_zero;
  assign stat.out_busy   = out_busy;

  lls_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idle_o (seq_idle)
  );

  lls_datapath #(
    .MaxOrder (MaxOrder)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .start_i         (stat.start),
    .coef_we_i       (in_accept && (command_i == CMD_LOAD_COEF)),
    .clear_i         (in_accept && (command_i == CMD_CLEAR)),
    .active_order_i  (active_order_q),
    .coef_index_i    (coef_index_i),
    .coef_value_i    (coef_value_i),
    .residual_i      (residual_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .output_sample_o (output_sample_o),
    .order_zero_o    (order_zero),
    .idx_zero_o      (idx_zero),
    .out_busy_o      (out_busy)
  );

endmodule
